// ----- rtl/core/dvt_pkg.sv -----
`timescale 1ns / 1ps

package dvt_pkg;

   localparam int SLOTS     = 1024;
   localparam int LABELS    = 1024;

   localparam int SLOT_W    = 10;   // width of the slot_index field
   localparam int LABEL_W   = 10;   // width of the new_label field
   localparam int TOTAL_W   = 11;   // width of the distinct_total field

   localparam int SLOT_AW   = $clog2(SLOTS);
   localparam int LABEL_AW  = $clog2(LABELS);
   localparam int POP_W     = $clog2(SLOTS + 1);

   localparam int CLR_DEPTH = (SLOTS > LABELS) ? SLOTS : LABELS;
   localparam int CLR_AW    = $clog2(CLR_DEPTH);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_OLD,
      ST_UPD_OLD,
      ST_UPD_NEW
   } state_type;

   typedef struct packed {
      logic                wr_en;
      logic [SLOT_AW-1:0]  wr_addr;
      logic [LABEL_W-1:0]  wr_data;
      logic [SLOT_AW-1:0]  rd_addr;
   } slot_mem_req_type;

   typedef struct packed {
      logic                wr_en;
      logic [LABEL_AW-1:0] wr_addr;
      logic [POP_W-1:0]    wr_data;
      logic [LABEL_AW-1:0] rd_addr;
   } pop_mem_req_type;

endpackage

// ----- rtl/core/dvt_ram.sv -----
`timescale 1ns / 1ps

module dvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/dvt_ctrl.sv -----
`timescale 1ns / 1ps

module dvt_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [dvt_pkg::SLOT_W-1:0]  req_slot_index,
   input  logic [dvt_pkg::LABEL_W-1:0] req_new_label,
   output logic                       rsp_strobe,
   output logic [dvt_pkg::TOTAL_W-1:0] rsp_distinct_total,
   output dvt_pkg::slot_mem_req_type  slot_req,
   input  logic [dvt_pkg::LABEL_W-1:0] slot_rd_data,
   output dvt_pkg::pop_mem_req_type   pop_req,
   input  logic [dvt_pkg::POP_W-1:0]   pop_rd_data
);

   import dvt_pkg::*;

   state_type            state_ff, state_in;
   logic [CLR_AW-1:0]    clr_ff, clr_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [LABEL_W-1:0]   label_ff, label_in;
   logic [LABEL_W-1:0]   old_ff, old_in;
   logic [POP_W-1:0]     pop_new_ff, pop_new_in;
   logic                 in_range_ff, in_range_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic                 strobe_ff, strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         total_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         total_ff  <= total_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      label_ff    <= label_in;
      old_ff      <= old_in;
      pop_new_ff  <= pop_new_in;
      in_range_ff <= in_range_in;
   end

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      slot_in     = slot_ff;
      label_in    = label_ff;
      old_in      = old_ff;
      pop_new_in  = pop_new_ff;
      in_range_in = in_range_ff;
      total_in    = total_ff;
      strobe_in   = 1'b0;
      busy        = 1'b1;

      slot_req.wr_en   = 1'b0;
      slot_req.wr_addr = SLOT_AW'(slot_ff);
      slot_req.wr_data = label_ff;
      slot_req.rd_addr = SLOT_AW'(req_slot_index);
      pop_req.wr_en    = 1'b0;
      pop_req.wr_addr  = LABEL_AW'(label_ff);
      pop_req.wr_data  = pop_new_ff + POP_W'(1);
      pop_req.rd_addr  = LABEL_AW'(req_new_label);

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep both memories to zero, one entry per cycle
            slot_req.wr_en   = 32'(clr_ff) < SLOTS;
            slot_req.wr_addr = SLOT_AW'(clr_ff);
            slot_req.wr_data = '0;
            pop_req.wr_en    = 32'(clr_ff) < LABELS;
            pop_req.wr_addr  = LABEL_AW'(clr_ff);
            pop_req.wr_data  = '0;
            clr_in = clr_ff + CLR_AW'(1);
            if (32'(clr_ff) == CLR_DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               slot_in     = req_slot_index;
               label_in    = req_new_label;
               in_range_in = (32'(req_slot_index) < SLOTS) && (32'(req_new_label) < LABELS);
               state_in    = ST_RD_OLD;
            end
         end
         ST_RD_OLD: begin
            old_in     = slot_rd_data;
            pop_new_in = pop_rd_data;
            pop_req.rd_addr = LABEL_AW'(slot_rd_data);
            if (!in_range_ff || slot_rd_data == label_ff) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_UPD_OLD;
            end
         end
         ST_UPD_OLD: begin
            // drop the old label and relabel the slot
            slot_req.wr_en  = 1'b1;
            pop_req.wr_en   = (old_ff != '0) && (pop_rd_data != '0);
            pop_req.wr_addr = LABEL_AW'(old_ff);
            pop_req.wr_data = pop_rd_data - POP_W'(1);
            if (pop_req.wr_en && pop_rd_data == POP_W'(1) && total_ff != '0) begin
               total_in = total_ff - TOTAL_W'(1);
            end
            state_in = ST_UPD_NEW;
         end
         ST_UPD_NEW: begin
            // old and new labels differ, so the population read earlier is current
            pop_req.wr_en = label_ff != '0;
            if (pop_req.wr_en && pop_new_ff == '0) begin
               total_in = total_ff + TOTAL_W'(1);
            end
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_distinct_total = total_ff;

endmodule

// ----- rtl/core/distinct_value_tracker.sv -----
`timescale 1ns / 1ps
// Distinct label tracker.
// Each slot holds a label (0 = unlabeled); the block keeps the number of
// slots per label and the number of nonzero labels that are in use.
// Input: an item (req_slot_index, req_new_label) is taken at a rising edge
// where start is high and busy is low. Busy stays high while the item is
// worked on; one item is in flight at a time.
// Output: exactly one result per item, rsp_distinct_total, valid for one
// cycle while rsp_strobe is high. The receiver cannot hold results off.
// The read of both memories starts at accept; in ST_RD_OLD the item ends
// with the result strobe when the slot already holds the label (or the
// item is out of range), else it goes on through ST_UPD_OLD and ST_UPD_NEW
// first. One item is taken at a time; the pace is set by the single write
// port of the population memory (old and new label updates take separate
// cycles) and the registered reads of both memories. Reset: synchronous,
// active high. After reset the block clears all 1024 entries of the slot
// and population memories, busy high; the distinct total starts at zero.

module distinct_value_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [dvt_pkg::SLOT_W-1:0]  req_slot_index,
   input  logic [dvt_pkg::LABEL_W-1:0] req_new_label,
   output logic                        rsp_strobe,
   output logic [dvt_pkg::TOTAL_W-1:0] rsp_distinct_total
);

   import dvt_pkg::*;

   slot_mem_req_type    slot_req;
   pop_mem_req_type     pop_req;
   logic [LABEL_W-1:0]  slot_rd_data;
   logic [POP_W-1:0]    pop_rd_data;

   dvt_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_slot_index     (req_slot_index),
      .req_new_label      (req_new_label),
      .rsp_strobe         (rsp_strobe),
      .rsp_distinct_total (rsp_distinct_total),
      .slot_req           (slot_req),
      .slot_rd_data       (slot_rd_data),
      .pop_req            (pop_req),
      .pop_rd_data        (pop_rd_data)
   );

   dvt_ram #(
      .WIDTH (LABEL_W),
      .DEPTH (SLOTS)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (slot_req.wr_en),
      .wr_addr (slot_req.wr_addr),
      .wr_data (slot_req.wr_data),
      .rd_addr (slot_req.rd_addr),
      .rd_data (slot_rd_data)
   );

   dvt_ram #(
      .WIDTH (POP_W),
      .DEPTH (LABELS)
   ) u_pop_mem (
      .clock   (clock),
      .wr_en   (pop_req.wr_en),
      .wr_addr (pop_req.wr_addr),
      .wr_data (pop_req.wr_data),
      .rd_addr (pop_req.rd_addr),
      .rd_data (pop_rd_data)
   );

endmodule
